### hdl/fwd_pkg.sv
// Shared types and constants for the four-wheel drive speed ramp.
// No dependencies; every other file in hdl/ imports this package.
`default_nettype none
package fwd_pkg;

  // Duty magnitude width of each wheel output
  localparam int DUTY_BITS = 8;
  localparam int DutyFull  = (1 << DUTY_BITS) - 1;

  // Signed width that holds any wheel sum, its negation and the clamp limit
  localparam int WHEEL_W = 12;

  // Stream payload widths
  localparam int IN_W        = 2 + 9 + 9;
  localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
  localparam int OUT_W       = 4 * (2 + DUTY_BITS);
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  // Configuration port
  localparam int ADDR_W = 4;

  typedef enum logic [1:0] {
    CMD_ADVANCE    = 2'd0,
    CMD_SOFT_STOP  = 2'd1,
    CMD_HARD_BRAKE = 2'd2,
    CMD_SPIN       = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    REG_MAX_DUTY    = 2'd0,
    REG_RAMP_STEP   = 2'd1,
    REG_INVERT_MASK = 2'd2,
    REG_UNUSED      = 2'd3
  } reg_e;

  typedef struct packed {
    logic [7:0] duty_lim;
    logic [7:0] ramp_step;
    logic [3:0] invert_mask;
  } cfg_t;

  typedef struct packed {
    logic signed [WHEEL_W-1:0] rr;
    logic signed [WHEEL_W-1:0] rl;
    logic signed [WHEEL_W-1:0] fr;
    logic signed [WHEEL_W-1:0] fl;
  } wheel_vals_t;

  // forward in the lowest bit, then reverse, then duty
  typedef struct packed {
    logic [DUTY_BITS-1:0] duty;
    logic                 reverse;
    logic                 forward;
  } wheel_out_t;

endpackage
`default_nettype wire

### hdl/fwd_cfg_regs.sv
// APB-style configuration registers: duty limit, ramp step and invert mask.
// Depends on fwd_pkg.
`default_nettype none
module fwd_cfg_regs (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     psel,
  input  wire                     penable,
  input  wire                     pwrite,
  input  wire [fwd_pkg::ADDR_W-1:0] paddr,
  input  wire [31:0]              pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  output fwd_pkg::cfg_t           cfg_o
);
  import fwd_pkg::*;

  logic [7:0] max_duty_q;
  logic [7:0] ramp_step_q;
  logic [3:0] invert_mask_q;
  logic       wr_en;
  reg_e       reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = reg_e'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_duty_q    <= 8'd255;
      ramp_step_q   <= 8'd10;
      invert_mask_q <= 4'd0;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_MAX_DUTY:    max_duty_q    <= pwdata[7:0];
        REG_RAMP_STEP:   ramp_step_q   <= pwdata[7:0];
        REG_INVERT_MASK: invert_mask_q <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_MAX_DUTY:    prdata = {24'd0, max_duty_q};
      REG_RAMP_STEP:   prdata = {24'd0, ramp_step_q};
      REG_INVERT_MASK: prdata = {28'd0, invert_mask_q};
      default:         prdata = 32'd0;
    endcase
  end

  // Cap the duty limit at the full scale of the duty field
  always_comb begin
    cfg_o.duty_lim    = (int'(max_duty_q) > DutyFull) ? 8'(DutyFull) : max_duty_q;
    cfg_o.ramp_step   = ramp_step_q;
    cfg_o.invert_mask = invert_mask_q;
  end

endmodule
`default_nettype wire

### hdl/fwd_ramp.sv
// Forward speed register and per-command ramp logic; yields four signed wheel values.
// Depends on fwd_pkg.
`default_nettype none
module fwd_ramp (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       step_en_i,
  input  fwd_pkg::cmd_e             cmd_i,
  input  wire signed [8:0]          speed_i,
  input  wire signed [8:0]          correction_i,
  input  wire [7:0]                 ramp_step_i,
  output fwd_pkg::wheel_vals_t      wheels_o
);
  import fwd_pkg::*;

  logic signed [8:0]  fwd_speed_q, fwd_speed_d;
  logic signed [10:0] fs_x, spd_x, step_x, raised, lowered, ramped, toward;
  logic signed [WHEEL_W-1:0] f_w, spd_w, corr_w, left_w, right_w;

  always_comb begin
    fs_x    = 11'(fwd_speed_q);
    spd_x   = 11'(speed_i);
    step_x  = $signed({3'b000, ramp_step_i});
    raised  = fs_x + step_x;
    lowered = fs_x - step_x;

    // Advance: step up toward the target, drop to it at once when above
    ramped = (fs_x < spd_x) ? raised : fs_x;
    if (ramped > spd_x) begin
      ramped = spd_x;
    end

    // Soft stop: move toward zero without crossing it
    if (fs_x > 11'sd0) begin
      toward = (lowered < 11'sd0) ? 11'sd0 : lowered;
    end else if (fs_x < 11'sd0) begin
      toward = (raised > 11'sd0) ? 11'sd0 : raised;
    end else begin
      toward = fs_x;
    end

    case (cmd_i)
      CMD_ADVANCE:    fwd_speed_d = 9'(ramped);
      CMD_SOFT_STOP:  fwd_speed_d = 9'(toward);
      CMD_HARD_BRAKE: fwd_speed_d = 9'sd0;
      default:        fwd_speed_d = fwd_speed_q;
    endcase

    f_w     = WHEEL_W'(fwd_speed_d);
    spd_w   = WHEEL_W'(speed_i);
    corr_w  = WHEEL_W'(correction_i);
    left_w  = f_w + corr_w;
    right_w = f_w - corr_w;

    case (cmd_i)
      CMD_ADVANCE: begin
        wheels_o.fl = left_w;
        wheels_o.rl = left_w;
        wheels_o.fr = right_w;
        wheels_o.rr = right_w;
      end
      CMD_SOFT_STOP: begin
        wheels_o.fl = f_w;
        wheels_o.rl = f_w;
        wheels_o.fr = f_w;
        wheels_o.rr = f_w;
      end
      CMD_HARD_BRAKE: begin
        wheels_o.fl = '0;
        wheels_o.rl = '0;
        wheels_o.fr = '0;
        wheels_o.rr = '0;
      end
      default: begin
        wheels_o.fl = spd_w;
        wheels_o.rl = spd_w;
        wheels_o.fr = -spd_w;
        wheels_o.rr = -spd_w;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_speed_q <= 9'sd0;
    end else if (step_en_i) begin
      fwd_speed_q <= fwd_speed_d;
    end
  end

endmodule
`default_nettype wire

### hdl/fwd_wheel.sv
// One wheel encoder: optional inversion, clamp to the duty limit, H-bridge encoding.
// Depends on fwd_pkg.
`default_nettype none
module fwd_wheel (
  input  wire signed [fwd_pkg::WHEEL_W-1:0] value_i,
  input  wire                               invert_i,
  input  wire [7:0]                         duty_lim_i,
  output fwd_pkg::wheel_out_t               wheel_o
);
  import fwd_pkg::*;

  logic signed [WHEEL_W-1:0] v, lim, clamped, mag;

  always_comb begin
    v   = invert_i ? -value_i : value_i;
    lim = $signed(WHEEL_W'(duty_lim_i));
    if (v > lim) begin
      clamped = lim;
    end else if (v < -lim) begin
      clamped = -lim;
    end else begin
      clamped = v;
    end
    mag = clamped[WHEEL_W-1] ? -clamped : clamped;

    wheel_o.forward = (clamped > $signed(WHEEL_W'(0)));
    wheel_o.reverse = clamped[WHEEL_W-1];
    wheel_o.duty    = DUTY_BITS'(mag);
  end

endmodule
`default_nettype wire

### hdl/four_wheel_drive_speed_ramp.sv
// Top level of the four-wheel drive speed ramp: input register, ramp logic, wheel
// encoders and result register. Depends on fwd_pkg, fwd_cfg_regs, fwd_ramp, fwd_wheel.
//
// Usage:
//   Commands enter on the s_axis channel (command, speed, correction) and each one
//   produces exactly one result on the m_axis channel: direction pins and duty for
//   the front-left, front-right, rear-left and rear-right wheels.
//   A command taken from s_axis is registered in the input stage, processed against the
//   forward speed register, and its result is captured in the result register.
//   Throughput: one command per cycle unless the receiver stalls; the forward speed
//   update is a single add, compare and select, so each command sees the speed left
//   by the one before. The input stage takes a new command while a finished result
//   waits in the output register; when the receiver stalls, the two stages fill and
//   s_axis_tready falls until m_axis_tready returns.
//   The APB-style port sets the duty limit, ramp step and per-wheel invert mask;
//   write it only while no command is in flight.
//   Reset clears both stages and the forward speed, and loads duty limit 255,
//   ramp step 10 and invert mask 0.
`default_nettype none
module four_wheel_drive_speed_ramp (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  // command [1:0], speed [10:2], correction [19:11], zero fill above
  input  wire [fwd_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  input  wire                               s_axis_tvalid,
  output logic                              s_axis_tready,
  // per wheel fl, fr, rl, rr from the lowest bit: forward, reverse, duty
  output logic [fwd_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  output logic                              m_axis_tvalid,
  input  wire                               m_axis_tready,
  input  wire                               psel,
  input  wire                               penable,
  input  wire                               pwrite,
  input  wire [fwd_pkg::ADDR_W-1:0]         paddr,
  input  wire [31:0]                        pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import fwd_pkg::*;

  cfg_t        cfg;
  wheel_vals_t wheels;
  wheel_out_t  fl_out, fr_out, rl_out, rr_out;

  logic              in_vld_q;
  cmd_e              in_cmd_q;
  logic signed [8:0] in_speed_q;
  logic signed [8:0] in_corr_q;
  logic              out_vld_q;
  logic [OUT_TDATA_W-1:0] out_data_q;
  logic              advance;

  // Move the held command into the result register when that register frees up
  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  fwd_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  fwd_ramp u_ramp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_en_i    (advance),
    .cmd_i        (in_cmd_q),
    .speed_i      (in_speed_q),
    .correction_i (in_corr_q),
    .ramp_step_i  (cfg.ramp_step),
    .wheels_o     (wheels)
  );

  fwd_wheel u_fl (
    .value_i    (wheels.fl),
    .invert_i   (cfg.invert_mask[0]),
    .duty_lim_i (cfg.duty_lim),
    .wheel_o    (fl_out)
  );

  fwd_wheel u_fr (
    .value_i    (wheels.fr),
    .invert_i   (cfg.invert_mask[1]),
    .duty_lim_i (cfg.duty_lim),
    .wheel_o    (fr_out)
  );

  fwd_wheel u_rl (
    .value_i    (wheels.rl),
    .invert_i   (cfg.invert_mask[2]),
    .duty_lim_i (cfg.duty_lim),
    .wheel_o    (rl_out)
  );

  fwd_wheel u_rr (
    .value_i    (wheels.rr),
    .invert_i   (cfg.invert_mask[3]),
    .duty_lim_i (cfg.duty_lim),
    .wheel_o    (rr_out)
  );

  // Input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_cmd_q   <= cmd_e'(s_axis_tdata[1:0]);
      in_speed_q <= $signed(s_axis_tdata[10:2]);
      in_corr_q  <= $signed(s_axis_tdata[19:11]);
    end
  end

  // Result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= OUT_TDATA_W'({rr_out, rl_out, fr_out, fl_out});
    end
  end

endmodule
`default_nettype wire

### sim/four_wheel_drive_speed_ramp_tb.sv
// Self-checking testbench for the four-wheel drive speed ramp: commands go in on the
// slave stream, wheel results are checked against a predictor of the ramp and clamp.
// Depends on fwd_pkg and the four_wheel_drive_speed_ramp RTL.
`timescale 1ns / 1ps
module four_wheel_drive_speed_ramp_tb;
  import fwd_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int HOLD_AT      = 600;
  localparam int HOLD_CYCLES  = 80;

  typedef struct packed {
    logic signed [8:0] correction;
    logic signed [8:0] speed;
    cmd_e              command;
  } drive_cmd_t;

  typedef wheel_out_t [3:0] wheel_set_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic                   psel          = 1'b0;
  logic                   penable       = 1'b0;
  logic                   pwrite        = 1'b0;
  logic [ADDR_W-1:0]      paddr         = '0;
  logic [31:0]            pwdata        = '0;
  logic [31:0]            prdata;
  logic                   pready;

  four_wheel_drive_speed_ramp u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #10 clk_i = ~clk_i;

  // Register mirror and speed state of the predictor
  int duty_limit = 255;
  int ramp_inc   = 10;
  bit [3:0] wheel_invert = 4'h0;
  int fwd_speed = 0;

  drive_cmd_t cmd_pending_q[$];
  wheel_set_t wheel_expect_q[$];
  drive_cmd_t cmd_offered;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int err_cnt       = 0;
  int results_seen  = 0;
  int hold_left     = 0;
  bit hold_done     = 1'b0;
  int cycle_cnt     = 0;
  wheel_set_t wheels_got;
  wheel_set_t wheels_want;
  string wheel_name [4] = '{"fl", "fr", "rl", "rr"};

  function automatic wheel_out_t encode_wheel(int v, bit inv);
    wheel_out_t w;
    int lim;
    lim = (duty_limit > DutyFull) ? DutyFull : duty_limit;
    if (inv) v = -v;
    if (v > lim) v = lim;
    if (v < -lim) v = -lim;
    w.forward = (v > 0);
    w.reverse = (v < 0);
    w.duty    = DUTY_BITS'((v < 0) ? -v : v);
    return w;
  endfunction

  task automatic predict_wheels(input drive_cmd_t c);
    int spd;
    int corr;
    int lft;
    int rgt;
    wheel_set_t ws;
    spd  = c.speed;
    corr = c.correction;
    case (c.command)
      CMD_ADVANCE: begin
        if (fwd_speed < spd) fwd_speed += ramp_inc;
        if (fwd_speed > spd) fwd_speed = spd;
        lft = fwd_speed + corr;
        rgt = fwd_speed - corr;
      end
      CMD_SOFT_STOP: begin
        // step toward zero without crossing it
        if (fwd_speed > 0) fwd_speed = (fwd_speed > ramp_inc) ? fwd_speed - ramp_inc : 0;
        else if (fwd_speed < 0) fwd_speed = (-fwd_speed > ramp_inc) ? fwd_speed + ramp_inc : 0;
        lft = fwd_speed;
        rgt = fwd_speed;
      end
      CMD_HARD_BRAKE: begin
        fwd_speed = 0;
        lft = 0;
        rgt = 0;
      end
      default: begin
        lft = spd;
        rgt = -spd;
      end
    endcase
    ws[0] = encode_wheel(lft, wheel_invert[0]);
    ws[1] = encode_wheel(rgt, wheel_invert[1]);
    ws[2] = encode_wheel(lft, wheel_invert[2]);
    ws[3] = encode_wheel(rgt, wheel_invert[3]);
    wheel_expect_q.push_back(ws);
  endtask

  // Sender: hold the offered transaction until accepted, idle at random between them
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) predict_wheels(cmd_offered);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (cmd_pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cmd_offered = cmd_pending_q.pop_front();
          s_axis_tdata  <= IN_TDATA_W'(cmd_offered);
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each result transaction, stall at random, hold off once for long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (wheel_expect_q.size() == 0) begin
          $error("result 0x%0h arrived with nothing expected", m_axis_tdata);
          err_cnt++;
        end else begin
          wheels_want = wheel_expect_q.pop_front();
          wheels_got  = wheel_set_t'(m_axis_tdata[OUT_W-1:0]);
          for (int w = 0; w < 4; w++) begin
            if (wheels_got[w].forward !== wheels_want[w].forward) begin
              $error("%s_forward: expected %0d, got %0d", wheel_name[w],
                     wheels_want[w].forward, wheels_got[w].forward);
              err_cnt++;
            end
            if (wheels_got[w].reverse !== wheels_want[w].reverse) begin
              $error("%s_reverse: expected %0d, got %0d", wheel_name[w],
                     wheels_want[w].reverse, wheels_got[w].reverse);
              err_cnt++;
            end
            if (wheels_got[w].duty !== wheels_want[w].duty) begin
              $error("%s_duty: expected %0d, got %0d", wheel_name[w],
                     wheels_want[w].duty, wheels_got[w].duty);
              err_cnt++;
            end
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (!hold_done && results_seen >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic apb_write(input reg_e idx, input logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_MAX_DUTY:    duty_limit   = val[7:0];
      REG_RAMP_STEP:   ramp_inc     = val[7:0];
      REG_INVERT_MASK: wheel_invert = val[3:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(input int duty, input int step, input int mask);
    apb_write(REG_MAX_DUTY, duty);
    apb_write(REG_RAMP_STEP, step);
    apb_write(REG_INVERT_MASK, mask);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (cmd_pending_q.size() != 0 || s_axis_tvalid || wheel_expect_q.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic push_cmd(input cmd_e c, input int spd, input int corr);
    drive_cmd_t d;
    d.command    = c;
    d.speed      = 9'(spd);
    d.correction = 9'(corr);
    cmd_pending_q.push_back(d);
  endtask

  function automatic int rand_s9();
    case ($urandom_range(9))
      0:       return 255;
      1:       return -255;
      2:       return 0;
      default: return int'($urandom_range(510)) - 255;
    endcase
  endfunction

  // Mostly ramp runs toward one target and soft-stop runs, with loose commands between
  task automatic fill_random(input int count);
    int made;
    int n;
    int target;
    made = 0;
    while (made < count) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: begin
          target = rand_s9();
          n = $urandom_range(15, 3);
          repeat (n) push_cmd(CMD_ADVANCE, target, rand_s9());
        end
        6, 7: begin
          n = $urandom_range(10, 1);
          repeat (n) push_cmd(CMD_SOFT_STOP, rand_s9(), rand_s9());
        end
        default: begin
          n = 1;
          push_cmd(cmd_e'($urandom_range(3)), rand_s9(), rand_s9());
        end
      endcase
      made += n;
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed pass on the reset settings: extremes, every command, ignored fields
    push_cmd(CMD_ADVANCE, 255, 255);
    push_cmd(CMD_ADVANCE, 255, -255);
    push_cmd(CMD_ADVANCE, 255, 0);
    push_cmd(CMD_SOFT_STOP, -255, 255);
    push_cmd(CMD_ADVANCE, -255, 0);
    push_cmd(CMD_ADVANCE, -255, -255);
    push_cmd(CMD_SOFT_STOP, 0, 0);
    push_cmd(CMD_SPIN, 255, -255);
    push_cmd(CMD_SPIN, -255, 255);
    push_cmd(CMD_SPIN, 0, 0);
    push_cmd(CMD_HARD_BRAKE, 255, -255);
    push_cmd(CMD_ADVANCE, 0, 0);
    push_cmd(CMD_SOFT_STOP, 123, -77);
    push_cmd(CMD_ADVANCE, 7, 3);
    push_cmd(CMD_SOFT_STOP, 0, 0);
    wait_drained();

    // Zero duty limit, zero ramp step, all wheels inverted
    set_regs(0, 0, 15);
    push_cmd(CMD_ADVANCE, 200, 50);
    push_cmd(CMD_ADVANCE, -40, 10);
    push_cmd(CMD_SOFT_STOP, 0, 0);
    push_cmd(CMD_SPIN, 200, 0);
    push_cmd(CMD_HARD_BRAKE, 0, 0);
    push_cmd(CMD_ADVANCE, 100, -100);
    wait_drained();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_regs(255, 255, 5);
        1: set_regs(100, 1, 10);
        2: set_regs(200, 37, 15);
        3: set_regs(1, 128, 0);
        4: set_regs(255, 10, 3);
        default: set_regs($urandom_range(255), $urandom_range(255, 1), $urandom_range(15));
      endcase
      if (ph < 2) begin
        send_idle_pct = 6;
        recv_idle_pct = 86;
      end else if (ph < 4) begin
        send_idle_pct = 86;
        recv_idle_pct = 6;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      fill_random(115);
      wait_drained();
    end

    repeat (10) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### sim.f
hdl/fwd_pkg.sv
hdl/fwd_cfg_regs.sv
hdl/fwd_ramp.sv
hdl/fwd_wheel.sv
hdl/four_wheel_drive_speed_ramp.sv
sim/four_wheel_drive_speed_ramp_tb.sv
